// ===== hdl/csv_byte_stream_field_splitter_top_defines.svh =====
// assertion macros shared by the csv field splitter rtl
`ifndef CSV_BYTE_STREAM_FIELD_SPLITTER_TOP_DEFINES_SVH
`define CSV_BYTE_STREAM_FIELD_SPLITTER_TOP_DEFINES_SVH

// property checked on the rising clock edge, held off during reset
`define CSVFS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked in the same cycle
`define CSVFS_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== hdl/csvfs_pkg.sv =====
// types, constants and parse step functions for the csv field splitter
package csvfs_pkg;

   // byte values
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] MARK0    = 8'hEF;
   localparam logic [7:0] MARK1    = 8'hBB;
   localparam logic [7:0] MARK2    = 8'hBF;
   localparam logic [7:0] DELIM_RESET = 8'd44;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_FIELD = 2'd1;
   localparam logic [1:0] KIND_ROW   = 2'd2;

   // results one input byte can cause, and one request at most
   localparam int MAX_RES = 4;
   localparam int CNT_W   = $clog2(MAX_RES + 1);

   typedef struct packed {
      logic quoted;
      logic quote_pend;
      logic cr_pend;
      logic line_open;
   } parse_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } result_type;

   // outcome of one byte through the parser
   typedef struct packed {
      parse_state_type  st;
      result_type [1:0] res;
      logic [1:0]       cnt;
   } feed_out_type;

   // collected results of one request
   typedef struct packed {
      result_type [MAX_RES-1:0] res;
      logic [CNT_W-1:0]         cnt;
   } acc_type;

   // full outcome of one request
   typedef struct packed {
      parse_state_type          parse;
      logic [1:0]               mark_seen;
      logic                     mark_done;
      result_type [MAX_RES-1:0] res;
      logic [CNT_W-1:0]         cnt;
   } step_out_type;

   // append one result to a feed outcome
   function automatic feed_out_type emit_fn(input feed_out_type f, input logic [1:0] kind,
                                            input logic [7:0] data);
      feed_out_type o;
      o = f;
      if (o.cnt == 2'd0) begin
         o.res[0].kind = kind;
         o.res[0].data = (kind == KIND_DATA) ? data : 8'd0;
      end else begin
         o.res[1].kind = kind;
         o.res[1].data = (kind == KIND_DATA) ? data : 8'd0;
      end
      o.cnt = o.cnt + 2'd1;
      return o;
   endfunction

   // byte that is neither LF nor a held CR
   function automatic feed_out_type plain_fn(input feed_out_type f, input logic [7:0] c,
                                             input logic [7:0] delim);
      feed_out_type o;
      o = f;
      if (c == CH_QUOTE) begin
         if (o.st.quoted) o.st.quote_pend = 1'b1;
         else o.st.quoted = 1'b1;
      end else if (c == delim && !o.st.quoted) begin
         o = emit_fn(o, KIND_FIELD, 8'd0);
      end else begin
         o = emit_fn(o, KIND_DATA, c);
      end
      return o;
   endfunction

   // one byte through the parser, with quote and CR lookahead
   function automatic feed_out_type feed_fn(input parse_state_type st, input logic [7:0] b,
                                            input logic [7:0] delim);
      feed_out_type o;
      logic         done;
      o      = '0;
      o.st   = st;
      done   = 1'b0;
      // quote seen inside quotes
      if (st.quote_pend) begin
         o.st.quote_pend = 1'b0;
         if (b == CH_QUOTE) begin
            o = emit_fn(o, KIND_DATA, CH_QUOTE);
            o.st.line_open = 1'b1;
            done = 1'b1;
         end else begin
            o.st.quoted = 1'b0;
         end
      end
      // held CR
      if (!done && st.cr_pend) begin
         o.st.cr_pend = 1'b0;
         if (b == CH_LF) begin
            o = emit_fn(o, KIND_ROW, 8'd0);
            o.st.quoted    = 1'b0;
            o.st.line_open = 1'b0;
            done = 1'b1;
         end else begin
            o = plain_fn(o, CH_CR, delim);
            o.st.quote_pend = 1'b0;
         end
      end
      // the byte itself
      if (!done) begin
         if (b == CH_LF) begin
            o = emit_fn(o, KIND_ROW, 8'd0);
            o.st.quoted    = 1'b0;
            o.st.line_open = 1'b0;
         end else begin
            o.st.line_open = 1'b1;
            if (b == CH_CR) o.st.cr_pend = 1'b1;
            else o = plain_fn(o, b, delim);
         end
      end
      return o;
   endfunction

   // append the results of one feed to the request's list
   function automatic acc_type append_fn(input acc_type a, input feed_out_type f);
      acc_type o;
      o = a;
      for (int k = 0; k < 2; k++) begin
         if (2'(k) < f.cnt && o.cnt < CNT_W'(MAX_RES)) begin
            o.res[o.cnt[CNT_W-2:0]] = f.res[k];
            o.cnt = o.cnt + CNT_W'(1);
         end
      end
      return o;
   endfunction

endpackage

// ===== hdl/csv_byte_stream_field_splitter_top.sv =====
// top level of the csv byte stream field splitter
//
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tdata: data_byte; tuser: end_of_file
// rsp     | out | rsp_tvalid/tready   | tdata: cell_byte; tuser: result_kind;
//         |     |                     | tlast: last_of_run
// csr     | in  | csr_wr_en           | csr_wr_data: delimiter_char
//
// one request per cycle when each causes at most one result and the result port
// does not stall; a request with more results holds the next request while they drain.
// parsing is combinational from the request port into the result register.
// reset is synchronous; it clears parse state and sets the delimiter to ','.
// a stalled result port stops request intake while any result waits.
`include "csv_byte_stream_field_splitter_top_defines.svh"

module csv_byte_stream_field_splitter_top import csvfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] end_of_file
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] cell_byte
   output logic [1:0] rsp_tuser,   // [1:0] result_kind
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]      delim_ff;
   logic [7:0]      delim_in;
   parse_state_type parse_ff;
   logic [1:0]      mark_seen_ff;
   logic            mark_done_ff;
   step_out_type    step;
   logic            req_accept;
   logic            can_load;
   result_type      rsp_res;
   logic            eof_accept;
   logic            parse_idle;
   logic            state_idle;
   logic            rsp_pop;
   logic            mid_pop;
   logic            busy_load;
   logic            last_pop;

   assign req_tready = can_load;
   assign req_accept = req_tvalid && can_load;
   assign delim_in   = csr_wr_en ? csr_wr_data : delim_ff;

   // delimiter register
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else begin
         delim_ff <= delim_in;
      end
   end

   // parse and mark state
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff     <= '0;
         mark_seen_ff <= 2'd0;
         mark_done_ff <= 1'b0;
      end else if (req_accept) begin
         parse_ff     <= step.parse;
         mark_seen_ff <= step.mark_seen;
         mark_done_ff <= step.mark_done;
      end
   end

   // per request parse step
   csvfs_step u_step (
      .parse       (parse_ff),
      .mark_seen   (mark_seen_ff),
      .mark_done   (mark_done_ff),
      .delim       (delim_ff),
      .data_byte   (req_tdata),
      .end_of_file (req_tuser),
      .step        (step)
   );

   // result register and drain
   csvfs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_res  (step.res),
      .load_cnt  (step.cnt),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = rsp_res.data;
   assign rsp_tuser = rsp_res.kind;

   // terms for the checks
   assign eof_accept = req_accept && req_tuser;
   assign parse_idle = (parse_ff == '0);
   assign state_idle = parse_idle && (mark_seen_ff == 2'd0) && !mark_done_ff;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign mid_pop    = rsp_pop && !rsp_tlast;
   assign busy_load  = req_accept && rsp_tvalid;
   assign last_pop   = rsp_pop && rsp_tlast;

   // checks
   `CSVFS_ASSERT_CLK(a_eof_clears, clock, reset, eof_accept |=> state_idle, "eof left state")
   `CSVFS_ASSERT_IMP(a_mark_first, clock, reset, !mark_done_ff, parse_idle, "parse during mark")
   `CSVFS_ASSERT_IMP(a_load_drain, clock, reset, busy_load, last_pop, "load while results wait")
   `CSVFS_ASSERT_CLK(a_run_unbroken, clock, reset, mid_pop |=> rsp_tvalid, "run broken early")

endmodule

// ===== hdl/csvfs_step.sv =====
// parse step: mark check, replay of held mark bytes and byte parsing for one request
module csvfs_step import csvfs_pkg::*; (
   input  parse_state_type parse,
   input  logic [1:0]      mark_seen,
   input  logic            mark_done,
   input  logic [7:0]      delim,
   input  logic [7:0]      data_byte,
   input  logic            end_of_file,
   output step_out_type    step
);

   logic [7:0]      expect_byte;
   logic            mark_match;
   logic            replay;
   logic            feed_byte;
   parse_state_type st_a;
   parse_state_type st_b;
   feed_out_type    f_a;
   feed_out_type    f_b;
   feed_out_type    f_c;
   feed_out_type    f_row;
   acc_type         acc;

   // expected next mark byte
   always_comb begin
      case (mark_seen)
         2'd0:    expect_byte = MARK0;
         2'd1:    expect_byte = MARK1;
         default: expect_byte = MARK2;
      endcase
   end

   assign mark_match = (data_byte == expect_byte);
   // held bytes are replayed at end of file or on a mark mismatch
   assign replay     = !mark_done && (end_of_file || !mark_match);
   assign feed_byte  = !end_of_file && (mark_done || !mark_match);

   // chain: held EF, held BB, then the byte itself
   always_comb begin
      f_a  = feed_fn(parse, MARK0, delim);
      st_a = (replay && mark_seen != 2'd0) ? f_a.st : parse;
      f_b  = feed_fn(st_a, MARK1, delim);
      st_b = (replay && mark_seen == 2'd2) ? f_b.st : st_a;
      f_c  = feed_fn(st_b, data_byte, delim);
      f_row = emit_fn('0, KIND_ROW, 8'd0);

      acc = '0;
      if (replay && mark_seen != 2'd0) acc = append_fn(acc, f_a);
      if (replay && mark_seen == 2'd2) acc = append_fn(acc, f_b);
      if (feed_byte) acc = append_fn(acc, f_c);
      if (end_of_file && st_b.line_open) acc = append_fn(acc, f_row);

      step           = '0;
      step.res       = acc.res;
      step.cnt       = acc.cnt;
      step.parse     = parse;
      step.mark_seen = mark_seen;
      step.mark_done = mark_done;
      if (end_of_file) begin
         // everything but the delimiter returns to reset
         step.parse     = '0;
         step.mark_seen = 2'd0;
         step.mark_done = 1'b0;
      end else if (!mark_done) begin
         if (mark_match) begin
            if (mark_seen != 2'd2) begin
               step.mark_seen = mark_seen + 2'd1;
            end else begin
               step.mark_done = 1'b1;
               step.mark_seen = 2'd0;
            end
         end else begin
            step.mark_done = 1'b1;
            step.mark_seen = 2'd0;
            step.parse     = f_c.st;
         end
      end else begin
         step.parse = f_c.st;
      end
   end

endmodule

// ===== hdl/csvfs_rsp_queue.sv =====
// result register: holds the results of one request and drains them in order
module csvfs_rsp_queue import csvfs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  result_type [MAX_RES-1:0] load_res,
   input  logic [CNT_W-1:0]         load_cnt,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output result_type               rsp_res,
   output logic                     rsp_last
);

   result_type [MAX_RES-1:0] ent_ff;
   result_type [MAX_RES-1:0] ent_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;
   logic                     pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_res   = ent_ff[0];
   assign rsp_last  = (cnt_ff == CNT_W'(1));
   assign pop       = rsp_valid && rsp_ready;
   // room when no result waits, or once the last pending result leaves this cycle
   assign can_load  = !rsp_valid || (rsp_last && rsp_ready);

   // shift out on pop, reload on a new request
   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         for (int i = 0; i < MAX_RES - 1; i++) ent_in[i] = ent_ff[i+1];
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (load) begin
         ent_in = load_res;
         cnt_in = load_cnt;
      end
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // result entries
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

// ===== sim/tb_csv_byte_stream_field_splitter_top.sv =====
// self-checking testbench for the csv byte stream field splitter
`timescale 1ns / 1ps

module tb_csv_byte_stream_field_splitter_top;
   import csvfs_pkg::*;

   // one cell result as seen on the result port
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } cell_result_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [7:0] d;
      logic       e;
      logic       typed;
      logic       n;
      logic [1:0] kind;
      logic [7:0] cbyte;
   } probe_row_type;

   localparam int PROBE_ROWS      = 30;
   localparam int N_PHASE         = 8;
   localparam int ITEMS_PER_PHASE = 24;
   localparam int DRAIN_CYCLES    = 8;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic       req_tuser   = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b1;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   // expected results in arrival order, and the ones of the current request
   cell_result_type cells_due [$];
   cell_result_type step_cells [$];
   int              mismatch_count = 0;
   logic            req_idle_on = 1'b1;
   logic            stall_on    = 1'b1;

   // parser shadow state
   logic [7:0] delim;
   logic       in_quotes, quote_held, cr_held, row_open;
   logic [1:0] mark_cnt;
   logic       mark_done;
   logic [7:0] mark_hold [2];

   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{8'h61,    1'b0, 1'b1, 1'b1, KIND_DATA,  8'h61},
      '{8'h2C,    1'b0, 1'b1, 1'b1, KIND_FIELD, 8'h00},
      '{CH_QUOTE, 1'b0, 1'b1, 1'b0, KIND_DATA,  8'h00},
      '{8'h78,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'h2C,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_CR,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_LF,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_LF,    1'b0, 1'b1, 1'b1, KIND_ROW,   8'h00},
      '{CH_CR,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'h62,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'hFF,    1'b0, 1'b1, 1'b1, KIND_DATA,  8'hFF},
      '{8'h00,    1'b0, 1'b1, 1'b1, KIND_DATA,  8'h00},
      '{8'h00,    1'b1, 1'b1, 1'b1, KIND_ROW,   8'h00},
      '{8'hFF,    1'b1, 1'b1, 1'b0, KIND_DATA,  8'h00},
      '{MARK0,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{MARK1,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{MARK2,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'h63,    1'b0, 1'b1, 1'b1, KIND_DATA,  8'h63},
      '{8'h5A,    1'b1, 1'b1, 1'b1, KIND_ROW,   8'h00},
      '{MARK0,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{MARK1,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'h00,    1'b1, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{MARK0,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'h71,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{CH_LF,    1'b0, 1'b0, 1'b0, KIND_DATA,  8'h00},
      '{8'hA5,    1'b1, 1'b1, 1'b0, KIND_DATA,  8'h00}
   };

   csv_byte_stream_field_splitter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("csv_byte_stream_field_splitter_top: mismatch");
      $finish;
   end

   // back to the start of a file; the delimiter is kept
   function automatic void clear_parser();
      in_quotes   = 1'b0;
      quote_held  = 1'b0;
      cr_held     = 1'b0;
      row_open    = 1'b0;
      mark_cnt    = 2'd0;
      mark_done   = 1'b0;
      mark_hold[0] = 8'h00;
      mark_hold[1] = 8'h00;
   endfunction

   function automatic void add_cell(input logic [1:0] k, input logic [7:0] b);
      cell_result_type r;
      if (step_cells.size() < MAX_RES) begin
         r.kind = k;
         r.data = (k == KIND_DATA) ? b : 8'h00;
         r.last = 1'b0;
         step_cells = {step_cells, r};
      end
   endfunction

   // byte that is neither LF nor a CR to hold
   function automatic void take_plain(input logic [7:0] b);
      if (b == CH_QUOTE) begin
         if (in_quotes) quote_held = 1'b1;
         else in_quotes = 1'b1;
      end else if (b == delim && !in_quotes) begin
         add_cell(KIND_FIELD, 8'h00);
      end else begin
         add_cell(KIND_DATA, b);
      end
   endfunction

   // one byte past the mark check, with quote and CR lookahead
   function automatic void take_byte(input logic [7:0] b);
      if (quote_held) begin
         quote_held = 1'b0;
         if (b == CH_QUOTE) begin
            add_cell(KIND_DATA, CH_QUOTE);
            row_open = 1'b1;
            return;
         end
         in_quotes = 1'b0;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         if (b == CH_LF) begin
            add_cell(KIND_ROW, 8'h00);
            in_quotes = 1'b0;
            row_open  = 1'b0;
            return;
         end
         take_plain(CH_CR);
         quote_held = 1'b0;
      end
      if (b == CH_LF) begin
         add_cell(KIND_ROW, 8'h00);
         in_quotes = 1'b0;
         row_open  = 1'b0;
         return;
      end
      row_open = 1'b1;
      if (b == CH_CR) begin
         cr_held = 1'b1;
         return;
      end
      take_plain(b);
   endfunction

   function automatic void replay_mark();
      for (int i = 0; i < 2; i++) begin
         if (i < int'(mark_cnt)) take_byte(mark_hold[i]);
      end
      mark_cnt = 2'd0;
   endfunction

   // results of one accepted request, into step_cells
   function automatic void split_request(input logic [7:0] d, input logic e);
      logic [7:0]      want_byte;
      cell_result_type r;
      step_cells.delete();
      if (e) begin
         if (!mark_done) replay_mark();
         quote_held = 1'b0;
         in_quotes  = 1'b0;
         cr_held    = 1'b0;
         if (row_open) add_cell(KIND_ROW, 8'h00);
         clear_parser();
      end else if (!mark_done) begin
         want_byte = (mark_cnt == 2'd0) ? MARK0 : (mark_cnt == 2'd1) ? MARK1 : MARK2;
         if (d == want_byte) begin
            if (mark_cnt < 2'd2) begin
               mark_hold[mark_cnt[0]] = d;
               mark_cnt = mark_cnt + 2'd1;
            end else begin
               mark_done = 1'b1;
               mark_cnt  = 2'd0;
            end
         end else begin
            mark_done = 1'b1;
            replay_mark();
            take_byte(d);
         end
      end else begin
         take_byte(d);
      end
      if (step_cells.size() > 0) begin
         r = step_cells[step_cells.size() - 1];
         r.last = 1'b1;
         step_cells[step_cells.size() - 1] = r;
      end
   endfunction

   // offer one request, wait for it to be taken, then queue its results
   task automatic send_req(input logic [7:0] d, input logic e, input logic typed,
                           input logic n, input logic [1:0] k, input logic [7:0] cb);
      cell_result_type r;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      split_request(d, e);
      if (typed) begin
         if (n) begin
            r.kind = k;
            r.data = cb;
            r.last = 1'b1;
            cells_due = {cells_due, r};
         end
      end else begin
         foreach (step_cells[i]) cells_due = {cells_due, step_cells[i]};
      end
   endtask

   // wait until every expected result is out and the block has settled
   task automatic wait_drained();
      while (cells_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result port back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cells_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d byte %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = cells_due.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.data ||
                rsp_tlast !== want.last) begin
               $display("%0t: expected kind %0d byte %h last %b, actual kind %0d byte %h last %b",
                        $time, want.kind, want.data, want.last,
                        rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [7:0] phase_delims [N_PHASE];
      logic [7:0] cur_delim;
      logic [7:0] d;
      logic       e;
      logic       fresh;
      logic [7:0] mark_q [$];
      int         pick;
      int         mark_len;

      phase_delims = '{8'h3B, 8'h00, CH_LF, CH_CR, CH_QUOTE, 8'hFF, 8'h00, DELIM_RESET};
      delim = DELIM_RESET;
      clear_parser();
      fresh = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset delimiter
      for (int i = 0; i < PROBE_ROWS; i++) begin
         send_req(probe_rows[i].d, probe_rows[i].e, probe_rows[i].typed, probe_rows[i].n,
                  probe_rows[i].kind, probe_rows[i].cbyte);
         fresh = probe_rows[i].e;
      end
      req_tvalid <= 1'b0;

      // random phases, one delimiter each
      for (int ph = 0; ph < N_PHASE; ph++) begin
         wait_drained();
         cur_delim = (ph == 6) ? 8'($urandom_range(0, 255)) : phase_delims[ph];
         csr_wr_en   <= 1'b1;
         csr_wr_data <= cur_delim;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         delim = cur_delim;
         req_idle_on = (ph < N_PHASE - 1) && ($urandom_range(0, 3) != 0);
         stall_on    = (ph < N_PHASE - 1) && ($urandom_range(0, 3) != 0);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // a new file often opens with all or part of the mark
            if (fresh && mark_q.size() == 0 && $urandom_range(0, 1) == 1) begin
               mark_len = $urandom_range(1, 3);
               mark_q = {mark_q, MARK0};
               if (mark_len > 1) mark_q = {mark_q, MARK1};
               if (mark_len > 2) mark_q = {mark_q, MARK2};
            end
            e = 1'b0;
            if (mark_q.size() != 0) begin
               d = mark_q.pop_front();
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 30) d = 8'($urandom_range(8'h61, 8'h7A));
               else if (pick < 42) d = delim;
               else if (pick < 54) d = CH_QUOTE;
               else if (pick < 62) d = CH_CR;
               else if (pick < 72) d = CH_LF;
               else if (pick < 77) begin
                  d = 8'($urandom_range(0, 255));
                  e = 1'b1;
               end else d = 8'($urandom_range(0, 255));
            end
            send_req(d, e, 1'b0, 1'b0, KIND_DATA, 8'h00);
            fresh = e;
         end
         req_tvalid <= 1'b0;
      end

      // drain and report
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && cells_due.size() == 0) begin
         $display("csv_byte_stream_field_splitter_top: match");
      end else begin
         $display("csv_byte_stream_field_splitter_top: mismatch");
      end
      $finish;
   end

endmodule
